// ===== src/bsrc_pkg.sv =====
// Shared codes and control types for the deadlock-avoidance allocator.
`timescale 1ns / 1ps

package bsrc_pkg;

   // Operation codes carried by req_mode.
   localparam logic [2:0] MODE_LOAD_ALLOC = 3'd0;
   localparam logic [2:0] MODE_LOAD_NEED  = 3'd1;
   localparam logic [2:0] MODE_LOAD_FREE  = 3'd2;
   localparam logic [2:0] MODE_CHECK      = 3'd3;
   localparam logic [2:0] MODE_REQUEST    = 3'd4;

   // Status codes returned on rsp_status.
   localparam logic [2:0] STATUS_LOADED   = 3'd0;
   localparam logic [2:0] STATUS_SAFE     = 3'd1;
   localparam logic [2:0] STATUS_UNSAFE   = 3'd2;
   localparam logic [2:0] STATUS_EXCEEDS  = 3'd3;
   localparam logic [2:0] STATUS_OVERFLOW = 3'd4;

   // Control broadcast from the sequencer to every process cell.
   typedef struct packed {
      logic write_alloc;
      logic write_need;
      logic apply_add;
      logic roll_back;
      logic start_test;
      logic pass_step;
   } cell_ctrl_type;

endpackage

// ===== src/bankers_safety_and_request_check_top.sv =====
// Top level of the deadlock-avoidance allocator: sequencer, free units and a chain of cells.
// Sequence: a load transaction passes through ST_EVAL and is answered from the registered
// reply; a check or a request that passes its checks also runs the safety test in ST_SAFE,
// one pass per cycle through the cell chain, before the registered reply. busy stays high until
// the result strobe, so a new transaction is accepted only after the previous one is answered.
// Synchronous reset clears every row, the free units and the sequencer; the receiver cannot stall.
`timescale 1ns / 1ps

module bankers_safety_and_request_check_top #(
   parameter int PROCESSES   = 4,
   parameter int RESOURCES   = 3,
   parameter int AMOUNT_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_mode,
   input  logic [1:0] req_process_index,
   input  logic [7:0] req_amount_0,
   input  logic [7:0] req_amount_1,
   input  logic [7:0] req_amount_2,
   output logic       rsp_valid,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_finish_order,
   output logic [2:0] rsp_order_length
);
   import bsrc_pkg::*;

   // The work vector can hold the free units plus every allocation row without wrapping.
   localparam int WORK_BITS  = AMOUNT_BITS + $clog2(PROCESSES + 1);
   localparam int INDEX_BITS = $clog2(PROCESSES);
   localparam int GRANT_BITS = $clog2(PROCESSES + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EVAL = 3'b010,
      ST_SAFE = 3'b100
   } state_type;

   typedef logic [RESOURCES-1:0][AMOUNT_BITS-1:0] row_type;

   state_type                             state_ff, state_in;
   logic [2:0]                            mode_ff;
   logic [1:0]                            proc_ff;
   row_type                               amt_ff, amt_in;
   row_type                               free_ff, free_in;
   logic [RESOURCES-1:0][WORK_BITS-1:0]   work_ff, work_in;
   logic [INDEX_BITS-1:0]                 pass_ff, pass_in;
   logic [GRANT_BITS-1:0]                 granted_ff, granted_in;
   logic [7:0]                            order_ff, order_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]                            rsp_status_ff, rsp_status_in;
   logic [7:0]                            rsp_order_ff, rsp_order_in;
   logic [2:0]                            rsp_length_ff, rsp_length_in;

   cell_ctrl_type                         ctrl;
   logic [PROCESSES-1:0]                  row_sel;
   logic                                  proc_ok;
   logic                                  accept;
   logic                                  req_fits;
   logic                                  req_over;
   logic [AMOUNT_BITS:0]                  alloc_sum;
   logic [1:0]                            grant_id_low;
   logic                                  safe;

   // Chain links: entry 0 feeds the lowest cell, the last entry leaves the highest one.
   logic                                  claim      [PROCESSES+1];
   row_type                               grant_alloc[PROCESSES+1];
   logic [INDEX_BITS-1:0]                 grant_id   [PROCESSES+1];
   row_type                               rd_alloc   [PROCESSES+1];
   row_type                               rd_need    [PROCESSES+1];

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // Amounts are taken to AMOUNT_BITS; resource types without a port receive zero.
   for (genvar j = 0; j < RESOURCES; j++) begin : g_amt
      if (j == 0) begin : g_r0
         assign amt_in[j] = AMOUNT_BITS'(req_amount_0);
      end else if (j == 1) begin : g_r1
         assign amt_in[j] = AMOUNT_BITS'(req_amount_1);
      end else if (j == 2) begin : g_r2
         assign amt_in[j] = AMOUNT_BITS'(req_amount_2);
      end else begin : g_rz
         assign amt_in[j] = '0;
      end
   end

   // Only a process index inside the configured population addresses a row.
   assign proc_ok = (32'(proc_ff) < PROCESSES);
   for (genvar p = 0; p < PROCESSES; p++) begin : g_sel
      assign row_sel[p] = proc_ok && (32'(proc_ff) == p);
   end

   assign claim[0]       = 1'b0;
   assign grant_alloc[0] = '0;
   assign grant_id[0]    = '0;
   assign rd_alloc[0]    = '0;
   assign rd_need[0]     = '0;

   for (genvar p = 0; p < PROCESSES; p++) begin : g_cell
      bsrc_cell #(
         .RESOURCES  (RESOURCES),
         .AMOUNT_BITS(AMOUNT_BITS),
         .WORK_BITS  (WORK_BITS),
         .INDEX_BITS (INDEX_BITS),
         .CELL_ID    (p)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (ctrl),
         .row_sel        (row_sel[p]),
         .amount         (amt_ff),
         .work           (work_ff),
         .claim_in       (claim[p]),
         .claim_out      (claim[p+1]),
         .grant_alloc_in (grant_alloc[p]),
         .grant_alloc_out(grant_alloc[p+1]),
         .grant_id_in    (grant_id[p]),
         .grant_id_out   (grant_id[p+1]),
         .rd_alloc_in    (rd_alloc[p]),
         .rd_alloc_out   (rd_alloc[p+1]),
         .rd_need_in     (rd_need[p]),
         .rd_need_out    (rd_need[p+1])
      );
   end

   // Request screening against the addressed rows and the free units.
   always_comb begin
      req_fits  = proc_ok;
      req_over  = 1'b0;
      alloc_sum = '0;
      for (int j = 0; j < RESOURCES; j++) begin
         if (amt_ff[j] > rd_need[PROCESSES][j]) req_fits = 1'b0;
         if (amt_ff[j] > free_ff[j]) req_fits = 1'b0;
         alloc_sum = {1'b0, rd_alloc[PROCESSES][j]} + {1'b0, amt_ff[j]};
         if (alloc_sum[AMOUNT_BITS]) req_over = 1'b1;
      end
   end

   assign grant_id_low = 2'(grant_id[PROCESSES]);

   always_comb begin
      state_in      = state_ff;
      free_in       = free_ff;
      work_in       = work_ff;
      pass_in       = pass_ff;
      granted_in    = granted_ff;
      order_in      = order_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_order_in  = rsp_order_ff;
      rsp_length_in = rsp_length_ff;
      ctrl          = '0;
      safe          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EVAL;
         end

         ST_EVAL: begin
            // Default reply is the all-zero load answer; request screening and the safety test override it.
            rsp_status_in = STATUS_LOADED;
            rsp_order_in  = '0;
            rsp_length_in = '0;
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
            pass_in       = '0;
            granted_in    = '0;
            order_in      = '0;
            case (mode_ff)
               MODE_LOAD_ALLOC: begin
                  ctrl.write_alloc = 1'b1;
               end
               MODE_LOAD_NEED: begin
                  ctrl.write_need = 1'b1;
               end
               MODE_LOAD_FREE: begin
                  free_in = amt_ff;
               end
               MODE_CHECK: begin
                  for (int j = 0; j < RESOURCES; j++) begin
                     work_in[j] = WORK_BITS'(free_ff[j]);
                  end
                  ctrl.start_test = 1'b1;
                  rsp_valid_in    = 1'b0;
                  state_in        = ST_SAFE;
               end
               MODE_REQUEST: begin
                  if (!req_fits) begin
                     rsp_status_in = STATUS_EXCEEDS;
                  end else if (req_over) begin
                     rsp_status_in = STATUS_OVERFLOW;
                  end else begin
                     // Apply the request tentatively and test the resulting state.
                     ctrl.apply_add  = 1'b1;
                     ctrl.start_test = 1'b1;
                     for (int j = 0; j < RESOURCES; j++) begin
                        free_in[j] = free_ff[j] - amt_ff[j];
                        work_in[j] = WORK_BITS'(free_in[j]);
                     end
                     rsp_valid_in = 1'b0;
                     state_in     = ST_SAFE;
                  end
               end
               default: begin
               end
            endcase
         end

         ST_SAFE: begin
            // One pass: the chain picks the lowest unfinished process that fits.
            ctrl.pass_step = 1'b1;
            if (claim[PROCESSES]) begin
               for (int j = 0; j < RESOURCES; j++) begin
                  work_in[j] = work_ff[j] + WORK_BITS'(grant_alloc[PROCESSES][j]);
               end
               if (32'(granted_ff) < 4) begin
                  order_in[{granted_ff[1:0], 1'b0} +: 2] = grant_id_low;
               end
               granted_in = granted_ff + GRANT_BITS'(1);
            end
            pass_in = pass_ff + INDEX_BITS'(1);
            if (pass_ff == INDEX_BITS'(PROCESSES - 1)) begin
               safe          = (32'(granted_in) == PROCESSES);
               rsp_valid_in  = 1'b1;
               rsp_order_in  = order_in;
               rsp_length_in = (32'(granted_in) > 7) ? 3'd7 : 3'(granted_in);
               rsp_status_in = safe ? STATUS_SAFE : STATUS_UNSAFE;
               state_in      = ST_IDLE;
               // An unsafe request is undone in the same cycle as the final pass.
               if (!safe && mode_ff == MODE_REQUEST) begin
                  ctrl.roll_back = 1'b1;
                  for (int j = 0; j < RESOURCES; j++) begin
                     free_in[j] = free_ff[j] + amt_ff[j];
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Transaction payload and test bookkeeping need no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         proc_ff <= req_process_index;
         amt_ff  <= amt_in;
      end
      work_ff       <= work_in;
      pass_ff       <= pass_in;
      granted_ff    <= granted_in;
      order_ff      <= order_in;
      rsp_status_ff <= rsp_status_in;
      rsp_order_ff  <= rsp_order_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_finish_order = rsp_order_ff;
   assign rsp_order_length = rsp_length_ff;

endmodule

// ===== src/bsrc_cell.sv =====
// One process cell: allocation row, need row, finished flag and chain links.
`timescale 1ns / 1ps

module bsrc_cell #(
   parameter int RESOURCES   = 3,
   parameter int AMOUNT_BITS = 8,
   parameter int WORK_BITS   = 11,
   parameter int INDEX_BITS  = 2,
   parameter int CELL_ID     = 0
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bsrc_pkg::cell_ctrl_type                ctrl,
   input  logic                                   row_sel,
   input  logic [RESOURCES-1:0][AMOUNT_BITS-1:0]  amount,
   input  logic [RESOURCES-1:0][WORK_BITS-1:0]    work,
   input  logic                                   claim_in,
   output logic                                   claim_out,
   input  logic [RESOURCES-1:0][AMOUNT_BITS-1:0]  grant_alloc_in,
   output logic [RESOURCES-1:0][AMOUNT_BITS-1:0]  grant_alloc_out,
   input  logic [INDEX_BITS-1:0]                  grant_id_in,
   output logic [INDEX_BITS-1:0]                  grant_id_out,
   input  logic [RESOURCES-1:0][AMOUNT_BITS-1:0]  rd_alloc_in,
   output logic [RESOURCES-1:0][AMOUNT_BITS-1:0]  rd_alloc_out,
   input  logic [RESOURCES-1:0][AMOUNT_BITS-1:0]  rd_need_in,
   output logic [RESOURCES-1:0][AMOUNT_BITS-1:0]  rd_need_out
);
   import bsrc_pkg::*;

   logic [RESOURCES-1:0][AMOUNT_BITS-1:0] alloc_ff, alloc_in;
   logic [RESOURCES-1:0][AMOUNT_BITS-1:0] need_ff, need_in;
   logic                                  done_ff, done_in;
   logic                                  fits;
   logic                                  sel;

   always_comb begin
      fits = 1'b1;
      for (int j = 0; j < RESOURCES; j++) begin
         if (WORK_BITS'(need_ff[j]) > work[j]) fits = 1'b0;
      end
   end

   // The lowest unfinished fitting cell wins; the claim ripples upwards.
   assign sel             = fits && !done_ff && !claim_in;
   assign claim_out       = claim_in || (fits && !done_ff);
   assign grant_alloc_out = sel ? alloc_ff : grant_alloc_in;
   assign grant_id_out    = sel ? INDEX_BITS'(CELL_ID) : grant_id_in;
   assign rd_alloc_out    = row_sel ? alloc_ff : rd_alloc_in;
   assign rd_need_out     = row_sel ? need_ff : rd_need_in;

   always_comb begin
      alloc_in = alloc_ff;
      need_in  = need_ff;
      done_in  = done_ff;
      if (row_sel) begin
         for (int j = 0; j < RESOURCES; j++) begin
            if (ctrl.write_alloc) alloc_in[j] = amount[j];
            if (ctrl.write_need) need_in[j] = amount[j];
            if (ctrl.apply_add) begin
               alloc_in[j] = alloc_ff[j] + amount[j];
               need_in[j]  = need_ff[j] - amount[j];
            end
            if (ctrl.roll_back) begin
               alloc_in[j] = alloc_ff[j] - amount[j];
               need_in[j]  = need_ff[j] + amount[j];
            end
         end
      end
      if (ctrl.start_test) done_in = 1'b0;
      else if (ctrl.pass_step && sel) done_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff <= '0;
         need_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         alloc_ff <= alloc_in;
         need_ff  <= need_in;
         done_ff  <= done_in;
      end
   end

endmodule
